FILE: rtl/dcfd_pkg.sv
// Shared types, constants and the CRC byte update for the drive command frame decoder.
// No dependencies; used by drive_command_frame_decoder.
package dcfd_pkg;

  // Frame geometry defaults.
  localparam int unsigned FRAME_BYTES_DEF = 32;
  localparam int unsigned CRC_OFFSET_DEF  = 30;
  // Bytes 0..29 hold the header and the decoded fields.
  localparam int unsigned FIELD_BYTES     = 30;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Register reset values.
  localparam logic [15:0] MAGIC_WORD_RST        = 16'd0;
  localparam logic [7:0]  PROTOCOL_VERSION_RST  = 8'd1;
  localparam logic [7:0]  COMMAND_TYPE_RST      = 8'd0;
  localparam logic [7:0]  UNICAST_LOW_RST       = 8'd1;
  localparam logic [7:0]  UNICAST_HIGH_RST      = 8'd254;
  localparam logic [7:0]  ALLOWED_FLAG_BITS_RST = 8'd0;
  localparam logic [15:0] SPEED_CEILING_RST     = 16'd32767;
  localparam logic [7:0]  SAFETY_STATE_TOP_RST  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_WORD        = 3'd0,
    CFG_PROTOCOL_VERSION  = 3'd1,
    CFG_COMMAND_TYPE      = 3'd2,
    CFG_UNICAST_LOW       = 3'd3,
    CFG_UNICAST_HIGH      = 3'd4,
    CFG_ALLOWED_FLAG_BITS = 3'd5,
    CFG_SPEED_CEILING     = 3'd6,
    CFG_SAFETY_STATE_TOP  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    VERDICT_OK      = 4'd0,
    VERDICT_LENGTH  = 4'd1,
    VERDICT_MAGIC   = 4'd2,
    VERDICT_VERSION = 4'd3,
    VERDICT_TYPE    = 4'd4,
    VERDICT_CRC     = 4'd5,
    VERDICT_ADDRESS = 4'd6,
    VERDICT_FLAGS   = 4'd7,
    VERDICT_RANGE   = 4'd8
  } verdict_e;

  // Result item; the last member sits in the lowest bits.
  typedef struct packed {
    logic [3:0]         pad;
    logic [31:0]        fault_bits;
    logic [15:0]        speed_limit_q15;
    logic signed [15:0] turn_demand;
    logic signed [15:0] forward_demand;
    logic [31:0]        made_at_ms;
    logic [31:0]        seq_number;
    logic [31:0]        session_id;
    logic [7:0]         safety_code;
    logic [7:0]         flag_bits;
    logic [7:0]         src_addr;
    logic [7:0]         dest_addr;
    verdict_e           verdict;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  // One byte through the CRC, most significant bit first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/drive_command_frame_decoder.sv
// Drive command frame decoder: byte-wide frame receiver, CRC check and field decode.
// Depends on dcfd_pkg for types, register reset values and the CRC byte update.
//
// Usage:
//   s_axis carries frame bytes in wire order, one per transfer, with tlast on the
//   final byte. Each byte updates the byte count, each byte ahead of the CRC field
//   updates the CRC, and frame bytes are captured into the field and CRC registers
//   in the same cycle, so a byte is taken every clock while s_axis_tready_o is high.
//   m_axis carries one result per frame, in the cycle after the transfer of the tlast
//   byte: a verdict code and the decoded fields, zeroed for early rejections.
//   The result sits in an output register. While it waits and the receiver holds
//   tready low, s_axis_tready_o drops; otherwise bytes keep flowing.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i), to be
//   used only while no frame is in flight.
//   Reset clears the receive state and the output valid flag, and returns the
//   configuration registers to their defaults; s_axis_tready_o is high once it ends.
module drive_command_frame_decoder #(
  parameter int unsigned FRAME_BYTES = dcfd_pkg::FRAME_BYTES_DEF,
  parameter int unsigned CRC_OFFSET  = dcfd_pkg::CRC_OFFSET_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Frame byte stream.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // data_byte
  input  logic                            s_axis_tlast_i,  // last_byte
  // Results.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // From bit 0: verdict, dest_addr, src_addr, flag_bits, safety_code, session_id,
  // seq_number, made_at_ms, forward_demand, turn_demand, speed_limit_q15,
  // fault_bits, zero pad.
  output logic [dcfd_pkg::RESULT_W-1:0]   m_axis_tdata_o,
  // Configuration writes.
  input  logic                            cfg_we_i,
  input  logic [dcfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dcfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned CntW     = $clog2(FRAME_BYTES + 1);
  localparam bit          LoInFrame = (CRC_OFFSET < FRAME_BYTES);
  localparam bit          HiInFrame = (CRC_OFFSET + 1 < FRAME_BYTES);

  // Configuration registers.
  logic [15:0] magic_word_q, speed_ceiling_q;
  logic [7:0]  protocol_version_q, command_type_q, unicast_low_q, unicast_high_q;
  logic [7:0]  allowed_flag_bits_q, safety_state_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q        <= dcfd_pkg::MAGIC_WORD_RST;
      protocol_version_q  <= dcfd_pkg::PROTOCOL_VERSION_RST;
      command_type_q      <= dcfd_pkg::COMMAND_TYPE_RST;
      unicast_low_q       <= dcfd_pkg::UNICAST_LOW_RST;
      unicast_high_q      <= dcfd_pkg::UNICAST_HIGH_RST;
      allowed_flag_bits_q <= dcfd_pkg::ALLOWED_FLAG_BITS_RST;
      speed_ceiling_q     <= dcfd_pkg::SPEED_CEILING_RST;
      safety_state_top_q  <= dcfd_pkg::SAFETY_STATE_TOP_RST;
    end else if (cfg_we_i) begin
      unique case (dcfd_pkg::cfg_idx_e'(cfg_idx_i))
        dcfd_pkg::CFG_MAGIC_WORD:        magic_word_q        <= cfg_wdata_i;
        dcfd_pkg::CFG_PROTOCOL_VERSION:  protocol_version_q  <= cfg_wdata_i[7:0];
        dcfd_pkg::CFG_COMMAND_TYPE:      command_type_q      <= cfg_wdata_i[7:0];
        dcfd_pkg::CFG_UNICAST_LOW:       unicast_low_q       <= cfg_wdata_i[7:0];
        dcfd_pkg::CFG_UNICAST_HIGH:      unicast_high_q      <= cfg_wdata_i[7:0];
        dcfd_pkg::CFG_ALLOWED_FLAG_BITS: allowed_flag_bits_q <= cfg_wdata_i[7:0];
        dcfd_pkg::CFG_SPEED_CEILING:     speed_ceiling_q     <= cfg_wdata_i;
        dcfd_pkg::CFG_SAFETY_STATE_TOP:  safety_state_top_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  logic out_valid_q;
  logic in_fire;
  logic out_fire;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire        = out_valid_q && m_axis_tready_i;

  // Receive state.
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d, crc_cur;
  logic            overlong_q, overlong_d;
  logic            store_en;

  assign store_en = (cnt_q < CntW'(FRAME_BYTES));

  always_comb begin
    crc_cur = crc_q;
    if (store_en && (cnt_q < CntW'(CRC_OFFSET))) begin
      crc_cur = dcfd_pkg::crc_byte(crc_q, s_axis_tdata_i);
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    overlong_d = overlong_q;
    if (in_fire) begin
      if (s_axis_tlast_i) begin
        cnt_d      = '0;
        crc_d      = dcfd_pkg::CRC_INIT;
        overlong_d = 1'b0;
      end else if (store_en) begin
        cnt_d = cnt_q + CntW'(1);
        crc_d = crc_cur;
      end else begin
        overlong_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      crc_q      <= dcfd_pkg::CRC_INIT;
      overlong_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      overlong_q <= overlong_d;
    end
  end

  // Captured frame bytes: each register takes the byte at its own position.
  logic [7:0] fb_q [dcfd_pkg::FIELD_BYTES];
  logic [7:0] crc_lo_q, crc_hi_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < dcfd_pkg::FIELD_BYTES; i++) begin
      if (in_fire && cnt_q == CntW'(i)) begin
        fb_q[i] <= s_axis_tdata_i;
      end
    end
    if (in_fire && store_en && cnt_q == CntW'(CRC_OFFSET)) begin
      crc_lo_q <= s_axis_tdata_i;
    end
    if (in_fire && store_en && cnt_q == CntW'(CRC_OFFSET + 1)) begin
      crc_hi_q <= s_axis_tdata_i;
    end
  end

  // The closing byte of a full frame may itself be a CRC byte, so look ahead.
  logic [7:0]  crc_lo_cur, crc_hi_cur;
  logic [15:0] crc_expected;

  always_comb begin
    crc_lo_cur = crc_lo_q;
    crc_hi_cur = crc_hi_q;
    if (store_en && cnt_q == CntW'(CRC_OFFSET)) begin
      crc_lo_cur = s_axis_tdata_i;
    end
    if (store_en && cnt_q == CntW'(CRC_OFFSET + 1)) begin
      crc_hi_cur = s_axis_tdata_i;
    end
    crc_expected = {HiInFrame ? crc_hi_cur : 8'h00, LoInFrame ? crc_lo_cur : 8'h00};
  end

  // Verdict and decoded fields for the frame closed by this byte.
  dcfd_pkg::result_t  res_d, res_q;
  dcfd_pkg::verdict_e verdict;
  logic               len_ok, dest_uni, src_uni;
  logic [31:0]        session;
  logic [15:0]        speed;

  assign session  = {fb_q[11], fb_q[10], fb_q[9], fb_q[8]};
  assign speed    = {fb_q[25], fb_q[24]};
  // A full frame is closed when this byte is number FRAME_BYTES.
  assign len_ok   = !overlong_q && (cnt_q == CntW'(FRAME_BYTES - 1));
  assign dest_uni = (fb_q[4] >= unicast_low_q) && (fb_q[4] <= unicast_high_q);
  assign src_uni  = (fb_q[5] >= unicast_low_q) && (fb_q[5] <= unicast_high_q);

  always_comb begin
    if (!len_ok) begin
      verdict = dcfd_pkg::VERDICT_LENGTH;
    end else if (fb_q[0] != magic_word_q[7:0] || fb_q[1] != magic_word_q[15:8]) begin
      verdict = dcfd_pkg::VERDICT_MAGIC;
    end else if (fb_q[2] != protocol_version_q) begin
      verdict = dcfd_pkg::VERDICT_VERSION;
    end else if (fb_q[3] != command_type_q) begin
      verdict = dcfd_pkg::VERDICT_TYPE;
    end else if (crc_expected != crc_cur) begin
      verdict = dcfd_pkg::VERDICT_CRC;
    end else if (!dest_uni || !src_uni || fb_q[4] == fb_q[5]) begin
      verdict = dcfd_pkg::VERDICT_ADDRESS;
    end else if ((fb_q[6] & ~allowed_flag_bits_q) != 8'h00) begin
      verdict = dcfd_pkg::VERDICT_FLAGS;
    end else if (session == 32'd0 || speed > speed_ceiling_q ||
                 fb_q[7] > safety_state_top_q) begin
      verdict = dcfd_pkg::VERDICT_RANGE;
    end else begin
      verdict = dcfd_pkg::VERDICT_OK;
    end
  end

  always_comb begin
    res_d = '0;
    if (verdict == dcfd_pkg::VERDICT_OK || verdict == dcfd_pkg::VERDICT_RANGE) begin
      res_d.dest_addr       = fb_q[4];
      res_d.src_addr        = fb_q[5];
      res_d.flag_bits       = fb_q[6];
      res_d.safety_code     = fb_q[7];
      res_d.session_id      = session;
      res_d.seq_number      = {fb_q[15], fb_q[14], fb_q[13], fb_q[12]};
      res_d.made_at_ms      = {fb_q[19], fb_q[18], fb_q[17], fb_q[16]};
      res_d.forward_demand  = {fb_q[21], fb_q[20]};
      res_d.turn_demand     = {fb_q[23], fb_q[22]};
      res_d.speed_limit_q15 = speed;
      res_d.fault_bits      = {fb_q[29], fb_q[28], fb_q[27], fb_q[26]};
    end
    res_d.verdict = verdict;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && s_axis_tlast_i) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

  // Checks.
  a_result_from_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && s_axis_tlast_i))
    else $error("result appeared without a closing byte");

  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast_i) |=> out_valid_q)
    else $error("closing byte did not produce a result");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FRAME_BYTES))
    else $error("byte count beyond frame size");

  a_overlong_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overlong_q |-> (cnt_q == CntW'(FRAME_BYTES)))
    else $error("overlong set before frame filled");

  a_reject_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.verdict != dcfd_pkg::VERDICT_OK &&
     res_q.verdict != dcfd_pkg::VERDICT_RANGE) |->
    (m_axis_tdata_o[dcfd_pkg::RESULT_W-1:4] == '0))
    else $error("early rejection carries nonzero fields");

endmodule
